[hw/rtl/nv12_rotate_address_generator_macros.svh]
// Assertion macros shared by the NV12 rotation address generator RTL.
// Depends on nothing; included by the files that carry assertions.
`ifndef NV12_ROTATE_ADDRESS_GENERATOR_MACROS_SVH
`define NV12_ROTATE_ADDRESS_GENERATOR_MACROS_SVH

// Same-cycle implication, off while reset is asserted.
`define NV12R_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("nv12 rotate: same-cycle property violated");

// Next-cycle implication, off while reset is asserted.
`define NV12R_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("nv12 rotate: next-cycle property violated");

`endif

[hw/rtl/nv12r_pkg.sv]
// Shared widths, limits, register indexes and stage types for the NV12 rotation
// address generator. Depends on nothing.
package nv12r_pkg;

  localparam int DIM_W  = 13;  // frame dimension registers
  localparam int CNT_W  = 12;  // column and row counters
  localparam int OFS_W  = 25;  // source byte offset
  localparam int CIDX_W = 2;   // configuration register index

  localparam logic [DIM_W-1:0] MAX_WIDTH    = 13'd4096;
  localparam logic [DIM_W-1:0] MAX_HEIGHT   = 13'd4096;
  localparam logic [DIM_W-1:0] RESET_WIDTH  = 13'd1920;
  localparam logic [DIM_W-1:0] RESET_HEIGHT = 13'd1080;

  typedef enum logic [CIDX_W-1:0] {
    CFG_FRAME_WIDTH  = 2'd0,
    CFG_FRAME_HEIGHT = 2'd1,
    CFG_ROTATE_DIR   = 2'd2
  } cfg_idx_e;

  // Offset = scale * width + addend, plus the word's flags.
  typedef struct packed {
    logic [DIM_W-1:0] scale;
    logic [DIM_W-1:0] addend;
    logic             plane;
    logic             last;
  } nv12r_term_t;

  // Clear bit 0, then clamp to 2..maxv.
  function automatic logic [DIM_W-1:0] even_clamp(input logic [DIM_W-1:0] v,
                                                  input logic [DIM_W-1:0] maxv);
    logic [DIM_W-1:0] ev;
    ev = {v[DIM_W-1:1], 1'b0};
    if (ev < 13'd2) begin
      ev = 13'd2;
    end
    if (ev > maxv) begin
      ev = maxv;
    end
    return ev;
  endfunction

endpackage

[hw/rtl/nv12r_walker.sv]
// Frame walk counters and the first pipeline stage of the NV12 rotation
// address generator. Depends on nv12r_pkg and the assertion macro header.
`include "nv12_rotate_address_generator_macros.svh"

module nv12r_walker
  import nv12r_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [DIM_W-1:0] width_i,
  input  logic [DIM_W-1:0] height_i,
  input  logic             rotate_dir_i,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic             restart_i,
  output logic             s1_valid_o,
  input  logic             s1_ready_i,
  output nv12r_term_t      s1_term_o
);

  logic [CNT_W-1:0] col_q, col_d, row_q, row_d;
  logic             phase_q, phase_d, pair_q, pair_d;
  logic             s1_valid_q, s1_valid_d;
  nv12r_term_t      term_q, term_d;

  logic             accept;
  logic             wipe;
  logic [DIM_W-1:0] hc, rows;
  logic [CNT_W-1:0] ei, ej;
  logic             eph, eps;
  logic [DIM_W-1:0] i13, j13, i1, i2, j1;

  assign in_ready_o = !s1_valid_q || s1_ready_i;
  assign accept     = in_valid_i && in_ready_o;
  assign hc         = {1'b0, height_i[DIM_W-1:1]};
  assign rows       = phase_q ? hc : height_i;

  // Restart, or a position outside the current geometry, starts a new frame.
  assign wipe = restart_i || ({1'b0, col_q} >= width_i) || ({1'b0, row_q} >= rows);
  assign ei   = wipe ? '0 : col_q;
  assign ej   = wipe ? '0 : row_q;
  assign eph  = wipe ? 1'b0 : phase_q;
  assign eps  = wipe ? 1'b0 : pair_q;

  assign i13 = {1'b0, ei};
  assign j13 = {1'b0, ej};
  assign i1  = i13 + 13'd1;
  assign i2  = i13 + 13'd2;
  assign j1  = j13 + 13'd1;

  always_comb begin
    col_d   = ei;
    row_d   = ej;
    phase_d = eph;
    pair_d  = eps;
    if (!eph) begin
      if (j1 >= height_i) begin
        row_d = '0;
        col_d = i1[CNT_W-1:0];
        if (i1 >= width_i) begin
          col_d   = '0;
          phase_d = 1'b1;
          pair_d  = 1'b0;
        end
      end else begin
        row_d = j1[CNT_W-1:0];
      end
    end else if (!eps) begin
      pair_d = 1'b1;
    end else begin
      pair_d = 1'b0;
      if (j1 >= hc) begin
        row_d = '0;
        col_d = i2[CNT_W-1:0];
        if (i2 >= width_i) begin
          col_d   = '0;
          phase_d = 1'b0;
        end
      end else begin
        row_d = j1[CNT_W-1:0];
      end
    end
  end

  always_comb begin
    term_d.plane = eph;
    term_d.last  = eph && eps && (i2 == width_i) && (j1 == hc);
    if (!eph) begin
      term_d.scale  = rotate_dir_i ? j13 : (height_i - 13'd1 - j13);
      term_d.addend = rotate_dir_i ? (width_i - 13'd1 - i13) : i13;
    end else begin
      term_d.scale  = rotate_dir_i ? (height_i + j13) : (height_i + hc - 13'd1 - j13);
      term_d.addend = (rotate_dir_i ? (width_i - 13'd2 - i13) : i13) + {12'd0, eps};
    end
  end

  assign s1_valid_d = accept || (s1_valid_q && !s1_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q      <= '0;
      row_q      <= '0;
      phase_q    <= 1'b0;
      pair_q     <= 1'b0;
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
      if (accept) begin
        col_q   <= col_d;
        row_q   <= row_d;
        phase_q <= phase_d;
        pair_q  <= pair_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      term_q <= term_d;
    end
  end

  assign s1_valid_o = s1_valid_q;
  assign s1_term_o  = term_q;

  `NV12R_ASSERT_IMP(a_pair_only_chroma, clk_i, rst_ni, !phase_q, !pair_q)
  `NV12R_ASSERT_NEXT(a_last_wraps, clk_i, rst_ni, accept && term_d.last,
                     col_q == '0 && row_q == '0 && !phase_q && !pair_q)
  `NV12R_ASSERT_NEXT(a_accept_fills, clk_i, rst_ni, accept, s1_valid_q)

endmodule

[hw/rtl/nv12r_offset.sv]
// Offset multiply-add and the result register of the NV12 rotation address
// generator. Depends on nv12r_pkg and the assertion macro header.
`include "nv12_rotate_address_generator_macros.svh"

module nv12r_offset
  import nv12r_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [DIM_W-1:0] width_i,
  input  logic             s1_valid_i,
  output logic             s1_ready_o,
  input  nv12r_term_t      s1_term_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [OFS_W-1:0] src_offset_o,
  output logic             plane_o,
  output logic             frame_last_o
);

  logic                 out_valid_q;
  logic                 take;
  logic [2*DIM_W-1:0]   product;
  logic [2*DIM_W-1:0]   sum;
  logic [OFS_W-1:0]     offset_q;
  logic                 plane_q, last_q;

  assign s1_ready_o = !out_valid_q || out_ready_i;
  assign take       = s1_valid_i && s1_ready_o;
  assign product    = s1_term_i.scale * width_i;
  assign sum        = product + {{DIM_W{1'b0}}, s1_term_i.addend};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= take || (out_valid_q && !out_ready_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      offset_q <= sum[OFS_W-1:0];
      plane_q  <= s1_term_i.plane;
      last_q   <= s1_term_i.last;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign src_offset_o = offset_q;
  assign plane_o      = plane_q;
  assign frame_last_o = last_q;

  `NV12R_ASSERT_IMP(a_last_is_chroma, clk_i, rst_ni, out_valid_q && last_q, plane_q)

endmodule

[hw/rtl/nv12_rotate_address_generator.sv]
// Top level of the NV12 rotation address generator: configuration registers,
// frame walker stage and offset stage. Depends on nv12r_pkg, nv12r_walker, nv12r_offset.
//
//  channel  | direction | handshake              | payload
//  ---------+-----------+------------------------+------------------------------------
//  in       | to block  | in_valid_i/in_ready_o  | restart_i
//  out      | from block| out_valid_o/out_ready_i| src_offset_o, plane_o, frame_last_o
//  cfg      | to block  | cfg_we_i (no wait)     | cfg_index_i, cfg_data_i
//
// One word per clock sustained while out_ready_i stays high. An accepted word is held in the
// walker stage register, then loaded into the result register and presented from there.
// Reset clears the walk counters, so the first word after reset is the first byte of a frame.
// Ready runs back through both stages: a stall on the output holds every stage in place,
// and new words keep flowing into any stage that has emptied.
// Configuration writes are taken without wait; width and height are stored even and clamped.

module nv12_rotate_address_generator
  import nv12r_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [CIDX_W-1:0] cfg_index_i,
  input  logic [DIM_W-1:0]  cfg_data_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              restart_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [OFS_W-1:0]  src_offset_o,
  output logic              plane_o,
  output logic              frame_last_o
);

  logic [DIM_W-1:0] width_q, height_q;
  logic             dir_q;
  logic             s1_valid, s1_ready;
  nv12r_term_t      s1_term;

  // Hold geometry already even and clamped; indexes past the list are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= RESET_WIDTH;
      height_q <= RESET_HEIGHT;
      dir_q    <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_FRAME_WIDTH:  width_q  <= even_clamp(cfg_data_i, MAX_WIDTH);
        CFG_FRAME_HEIGHT: height_q <= even_clamp(cfg_data_i, MAX_HEIGHT);
        CFG_ROTATE_DIR:   dir_q    <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Advance the frame walk and form the multiply-add terms.
  nv12r_walker u_walker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .width_i      (width_q),
    .height_i     (height_q),
    .rotate_dir_i (dir_q),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .restart_i    (restart_i),
    .s1_valid_o   (s1_valid),
    .s1_ready_i   (s1_ready),
    .s1_term_o    (s1_term)
  );

  // Scale by the width, add the column term and register the word.
  nv12r_offset u_offset (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .width_i      (width_q),
    .s1_valid_i   (s1_valid),
    .s1_ready_o   (s1_ready),
    .s1_term_i    (s1_term),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .src_offset_o (src_offset_o),
    .plane_o      (plane_o),
    .frame_last_o (frame_last_o)
  );

endmodule
